// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Result kinds
  localparam logic [1:0] RK_DATA  = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // Error codes
  localparam logic [3:0] ERR_CTRL_CHAR    = 4'd0;
  localparam logic [3:0] ERR_TRUNC_ESC    = 4'd1;
  localparam logic [3:0] ERR_BAD_ESC      = 4'd2;
  localparam logic [3:0] ERR_TRUNC_U      = 4'd3;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
  localparam logic [3:0] ERR_NO_LOW       = 4'd5;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd7;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd8;
  localparam logic [3:0] ERR_NO_OPEN      = 4'd9;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Input beat
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       last;
  } out_beat_t;

  // Command from front to back
  typedef enum logic [1:0] {
    CMD_BYTE,   // one literal byte in cp[7:0]
    CMD_CP,     // code point to encode as UTF-8
    CMD_DONE,   // closing quote
    CMD_ERR     // error with code in err
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [20:0] cp;
    logic [3:0]  err;
  } cmd_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // UTF-8 length minus one for a code point
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] r;
    if (cp <= 21'h7F) begin
      r = 2'd0;
    end else if (cp <= 21'h7FF) begin
      r = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // UTF-8 byte at position idx of a sequence of length len_m1 + 1
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                           input logic [1:0]  len_m1,
                                           input logic [1:0]  idx);
    logic [1:0] rem;
    logic [7:0] r;
    rem = len_m1 - idx;
    if (idx == 2'd0) begin
      case (len_m1)
        2'd0:    r = {1'b0, cp[6:0]};
        2'd1:    r = {3'b110, cp[10:6]};
        2'd2:    r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    r = {2'b10, cp[5:0]};
        2'd1:    r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

endpackage

// File: hdl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser: walks the string grammar one accepted input byte per cycle and
// issues at most one command per byte toward the back end.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  jsu_pkg::in_beat_t beat_i,
  output logic             cmd_valid_o,
  output jsu_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_QUAD1,
    MODE_WBS,
    MODE_WU,
    MODE_QUAD2
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] hex_val_q, hex_val_d;
  logic        hex_bad_q, hex_bad_d;
  logic [9:0]  high_q, high_d;

  logic        is_end;
  logic [7:0]  b;
  logic [4:0]  dig;
  logic [15:0] val_next;
  logic        bad_next;
  logic        err_hit;
  logic [3:0]  err_code;

  assign is_end   = (beat_i.action == jsu_pkg::ACT_END);
  assign b        = beat_i.data_byte;
  assign dig      = jsu_pkg::hex_digit(b);
  assign val_next = {hex_val_q[11:0], dig[3:0]};
  assign bad_next = hex_bad_q | ~dig[4];

  // Next state and command
  always_comb begin
    mode_d      = mode_q;
    hex_cnt_d   = hex_cnt_q;
    hex_val_d   = hex_val_q;
    hex_bad_d   = hex_bad_q;
    high_d      = high_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{op: jsu_pkg::CMD_BYTE, cp: 21'd0, err: 4'd0};
    err_hit     = 1'b0;
    err_code    = jsu_pkg::ERR_CTRL_CHAR;

    unique case (mode_q)
      MODE_BODY: begin
        if (is_end) begin
          err_hit  = 1'b1;
          err_code = jsu_pkg::ERR_UNTERMINATED;
        end else if (b == 8'h22) begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = jsu_pkg::CMD_DONE;
          mode_d      = MODE_IDLE;
        end else if (b < 8'h20) begin
          err_hit  = 1'b1;
          err_code = jsu_pkg::ERR_CTRL_CHAR;
        end else if (b == 8'h5C) begin
          mode_d = MODE_ESC;
        end else begin
          cmd_valid_o = 1'b1;
          cmd_o.cp    = {13'd0, b};
        end
      end

      MODE_ESC: begin
        if (is_end) begin
          err_hit  = 1'b1;
          err_code = jsu_pkg::ERR_TRUNC_ESC;
        end else begin
          mode_d      = MODE_BODY;
          cmd_valid_o = 1'b1;
          case (b)
            8'h22, 8'h5C, 8'h2F: cmd_o.cp = {13'd0, b};
            8'h62:               cmd_o.cp = 21'h08;
            8'h66:               cmd_o.cp = 21'h0C;
            8'h6E:               cmd_o.cp = 21'h0A;
            8'h72:               cmd_o.cp = 21'h0D;
            8'h74:               cmd_o.cp = 21'h09;
            8'h75: begin
              cmd_valid_o = 1'b0;
              mode_d      = MODE_QUAD1;
              hex_cnt_d   = 2'd0;
              hex_val_d   = 16'd0;
              hex_bad_d   = 1'b0;
            end
            default: begin
              cmd_valid_o = 1'b0;
              err_hit     = 1'b1;
              err_code    = jsu_pkg::ERR_BAD_ESC;
            end
          endcase
        end
      end

      MODE_QUAD1, MODE_QUAD2: begin
        if (is_end) begin
          err_hit  = 1'b1;
          err_code = jsu_pkg::ERR_TRUNC_U;
        end else begin
          hex_val_d = val_next;
          hex_bad_d = bad_next;
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else begin
            hex_cnt_d = 2'd0;
            if (bad_next) begin
              err_hit  = 1'b1;
              err_code = jsu_pkg::ERR_BAD_HEX;
            end else if (mode_q == MODE_QUAD1) begin
              if (val_next[15:10] == 6'b110110) begin
                // high surrogate: wait for the low half
                high_d = val_next[9:0];
                mode_d = MODE_WBS;
              end else if (val_next[15:10] == 6'b110111) begin
                err_hit  = 1'b1;
                err_code = jsu_pkg::ERR_LONE_LOW;
              end else begin
                cmd_valid_o = 1'b1;
                cmd_o.op    = jsu_pkg::CMD_CP;
                cmd_o.cp    = {5'd0, val_next};
                mode_d      = MODE_BODY;
              end
            end else begin
              if (val_next[15:10] != 6'b110111) begin
                err_hit  = 1'b1;
                err_code = jsu_pkg::ERR_BAD_LOW;
              end else begin
                // 0x10000 + (high << 10) + low offset
                cmd_valid_o = 1'b1;
                cmd_o.op    = jsu_pkg::CMD_CP;
                cmd_o.cp    = 21'h10000 + {1'b0, high_q, val_next[9:0]};
                mode_d      = MODE_BODY;
              end
            end
          end
        end
      end

      MODE_WBS: begin
        if (is_end || b != 8'h5C) begin
          err_hit  = 1'b1;
          err_code = jsu_pkg::ERR_NO_LOW;
        end else begin
          mode_d = MODE_WU;
        end
      end

      MODE_WU: begin
        if (is_end || b != 8'h75) begin
          err_hit  = 1'b1;
          err_code = jsu_pkg::ERR_NO_LOW;
        end else begin
          mode_d    = MODE_QUAD2;
          hex_cnt_d = 2'd0;
          hex_val_d = 16'd0;
          hex_bad_d = 1'b0;
        end
      end

      default: begin
        mode_d = MODE_IDLE;
        if (!is_end) begin
          if (b == 8'h22) begin
            mode_d = MODE_BODY;
          end else begin
            err_hit  = 1'b1;
            err_code = jsu_pkg::ERR_NO_OPEN;
          end
        end
      end
    endcase

    // Any error ends the string
    if (err_hit) begin
      cmd_valid_o = 1'b1;
      cmd_o.op    = jsu_pkg::CMD_ERR;
      cmd_o.cp    = 21'd0;
      cmd_o.err   = err_code;
      mode_d      = MODE_IDLE;
    end

    // Only advance on an accepted beat
    if (!accept_i) begin
      mode_d      = mode_q;
      hex_cnt_d   = hex_cnt_q;
      hex_val_d   = hex_val_q;
      hex_bad_d   = hex_bad_q;
      high_d      = high_q;
      cmd_valid_o = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      hex_cnt_q <= 2'd0;
      hex_val_q <= 16'd0;
      hex_bad_q <= 1'b0;
      high_q    <= 10'd0;
    end else begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      hex_val_q <= hex_val_d;
      hex_bad_q <= hex_bad_d;
      high_q    <= high_d;
    end
  end

endmodule

// File: hdl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short command queue between parser and UTF-8 emitter.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output jsu_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  jsu_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: hdl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Emitter: expands each command into one to four output beats and holds
// them in an output register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  jsu_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_beat_t out_data_o
);

  logic               cur_valid_q;
  jsu_pkg::cmd_t      cur_q;
  logic [1:0]         len_m1_q;
  logic [1:0]         idx_q;
  logic               out_valid_q;
  jsu_pkg::out_beat_t out_q;

  logic               load_out;
  logic               last_beat;
  jsu_pkg::out_beat_t beat;

  assign load_out    = cur_valid_q && (!out_valid_q || out_ready_i);
  assign last_beat   = (idx_q == len_m1_q);
  assign cmd_pop_o   = !cmd_empty_i && (!cur_valid_q || (load_out && last_beat));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Beat for the current command position
  always_comb begin
    beat = '{result_kind: jsu_pkg::RK_DATA, out_byte: 8'd0, error_code: 4'd0,
             last: last_beat};
    case (cur_q.op)
      jsu_pkg::CMD_BYTE: beat.out_byte = cur_q.cp[7:0];
      jsu_pkg::CMD_CP:   beat.out_byte = jsu_pkg::utf8_byte(cur_q.cp, len_m1_q, idx_q);
      jsu_pkg::CMD_DONE: beat.result_kind = jsu_pkg::RK_DONE;
      default: begin
        beat.result_kind = jsu_pkg::RK_ERROR;
        beat.error_code  = cur_q.err;
      end
    endcase
  end

  // Current command and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      len_m1_q    <= 2'd0;
      idx_q       <= 2'd0;
    end else if (cmd_pop_o) begin
      cur_valid_q <= 1'b1;
      len_m1_q    <= (cmd_i.op == jsu_pkg::CMD_CP) ? jsu_pkg::utf8_len_m1(cmd_i.cp) : 2'd0;
      idx_q       <= 2'd0;
    end else if (load_out) begin
      if (last_beat) begin
        cur_valid_q <= 1'b0;
      end
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= beat;
    end
  end

endmodule

// File: hdl/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Decodes a quoted JSON string byte stream into UTF-8 output beats.
// ----------------------------------------------------------------------------
// The unit takes one input byte per clock whenever the command queue has
// room, and gives one output beat per clock whenever a command is pending
// and the consumer is ready. Each input byte is parsed in its own cycle and
// leaves at most one command in a QueueDepth-entry queue; the emitter turns
// a command into one beat (literal byte, completion, error) or into one to
// four beats for a \u escape. A single \u escape takes six input bytes and
// gives up to three output beats; only a surrogate pair, twelve input bytes,
// gives four beats. An accepted byte passes through the queue, the
// current-command register and the output register before its first beat.
module json_string_unescape_utf8_unit #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jsu_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_beat_t out_data_o
);

  logic          accept;
  logic          cmd_valid;
  jsu_pkg::cmd_t cmd;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  jsu_pkg::cmd_t q_head;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .beat_i      (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_valid),
    .push_data_i (cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_head),
    .empty_o     (q_empty)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
